/* hw/rtl/b64c_pkg.sv */
package b64c_pkg;

  // depth of the job queue between front and back
  localparam int JOB_DEPTH = 2;

  localparam logic [7:0] CHAR_PAD      = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH    = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;  // '9'
  localparam logic [7:0] LOWER_OFFSET  = 8'd71;  // 'a' - 26
  localparam logic [7:0] DIGIT_OFFSET  = 8'd4;   // 52 - '0'
  localparam logic [5:0] VAL_PLUS      = 6'd62;
  localparam logic [5:0] VAL_SLASH     = 6'd63;
  localparam logic [5:0] VAL_LOWER_LO  = 6'd26;
  localparam logic [5:0] VAL_DIGIT_LO  = 6'd52;

  // one accepted item's worth of results, up to four beats
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt;       // number of beats minus one
    logic            has_data;  // low only for the empty end marker
    logic            last;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < VAL_LOWER_LO) begin
      c = 8'(v) + CHAR_UPPER_A;
    end else if (v < VAL_DIGIT_LO) begin
      c = 8'(v) + LOWER_OFFSET;
    end else if (v < VAL_PLUS) begin
      c = 8'(v) - DIGIT_OFFSET;
    end else if (v == VAL_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // anything outside the alphabet counts as zero
  function automatic logic [5:0] b64_value(input logic [7:0] c);
    logic [5:0] v;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      v = 6'(c - CHAR_UPPER_A);
    end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      v = 6'(c - LOWER_OFFSET);
    end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      v = 6'(c + DIGIT_OFFSET);
    end else if (c == CHAR_PLUS) begin
      v = VAL_PLUS;
    end else if (c == CHAR_SLASH) begin
      v = VAL_SLASH;
    end else begin
      v = 6'd0;
    end
    return v;
  endfunction

endpackage

/* hw/rtl/b64c_front.sv */
module b64c_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             job_valid,
  output b64c_pkg::job_t   job
);

  logic       mode_r, mode_nxt;
  logic [5:0] hold_r, hold_nxt;   // pending bits, low aligned, rest zero
  logic [1:0] cnt_r, cnt_nxt;     // pending bit count in pairs
  logic [2:0] n_res;
  logic [5:0] val;

  always_comb begin
    job      = '0;
    n_res    = 3'd0;
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    val      = b64c_pkg::b64_value(in_byte);
    job.has_data = 1'b1;
    job.last     = in_last;
    if (!mode_r) begin
      case (cnt_r)
        2'd0: begin
          job.bytes[0] = b64c_pkg::b64_char(in_byte[7:2]);
          n_res        = 3'd1;
          hold_nxt     = {4'b0, in_byte[1:0]};
          cnt_nxt      = 2'd1;
          if (in_last) begin
            job.bytes[1] = b64c_pkg::b64_char({in_byte[1:0], 4'b0});
            job.bytes[2] = b64c_pkg::CHAR_PAD;
            job.bytes[3] = b64c_pkg::CHAR_PAD;
            n_res        = 3'd4;
          end
        end
        2'd1: begin
          job.bytes[0] = b64c_pkg::b64_char({hold_r[1:0], in_byte[7:4]});
          n_res        = 3'd1;
          hold_nxt     = {2'b0, in_byte[3:0]};
          cnt_nxt      = 2'd2;
          if (in_last) begin
            job.bytes[1] = b64c_pkg::b64_char({in_byte[3:0], 2'b0});
            job.bytes[2] = b64c_pkg::CHAR_PAD;
            n_res        = 3'd3;
          end
        end
        default: begin
          job.bytes[0] = b64c_pkg::b64_char({hold_r[3:0], in_byte[7:6]});
          job.bytes[1] = b64c_pkg::b64_char(in_byte[5:0]);
          n_res        = 3'd2;
          hold_nxt     = 6'd0;
          cnt_nxt      = 2'd0;
        end
      endcase
    end else if (in_byte != b64c_pkg::CHAR_PAD) begin
      case (cnt_r)
        2'd0: begin
          hold_nxt = val;
          cnt_nxt  = 2'd3;
        end
        2'd1: begin
          job.bytes[0] = {hold_r[1:0], val};
          n_res        = 3'd1;
          hold_nxt     = 6'd0;
          cnt_nxt      = 2'd0;
        end
        2'd2: begin
          job.bytes[0] = {hold_r[3:0], val[5:2]};
          n_res        = 3'd1;
          hold_nxt     = {4'b0, val[1:0]};
          cnt_nxt      = 2'd1;
        end
        default: begin
          job.bytes[0] = {hold_r[5:0], val[5:4]};
          n_res        = 3'd1;
          hold_nxt     = {2'b0, val[3:0]};
          cnt_nxt      = 2'd2;
        end
      endcase
    end
    if (in_last) begin
      hold_nxt = 6'd0;
      cnt_nxt  = 2'd0;
      if (n_res == 3'd0) begin
        job.bytes    = '0;
        job.has_data = 1'b0;
        n_res        = 3'd1;
      end
    end
    job.cnt   = 2'(n_res - 3'd1);
    job_valid = accept && (n_res != 3'd0);
    if (!accept) begin
      hold_nxt = hold_r;
      cnt_nxt  = cnt_r;
    end
    if (cfg_we) begin
      mode_nxt = cfg_data;
      hold_nxt = 6'd0;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      hold_r <= 6'd0;
      cnt_r  <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      hold_r <= hold_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // a finished message leaves nothing pending
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> cnt_r == 2'd0 && hold_r == 6'd0)
    else $error("pending bits survive end of message");

  // encode never holds a six bit group
  a_enc_count: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> cnt_r != 2'd3)
    else $error("encode pending count out of range");

endmodule

/* hw/rtl/b64c_queue.sv */
module b64c_queue #(
  parameter int DEPTH = b64c_pkg::JOB_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output b64c_pkg::job_t rdata,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64c_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full  = fill_r == CNT_W'(DEPTH);
  assign empty = fill_r == '0;
  assign rdata = mem[rd_r];

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

endmodule

/* hw/rtl/b64c_back.sv */
module b64c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  b64c_pkg::job_t q_rdata,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_has_data,
  output logic           out_last
);

  b64c_pkg::job_t job_r;
  logic           busy_r, busy_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           done, take;

  assign done = idx_r == job_r.cnt;
  assign take = pop && busy_r;
  assign q_pop = (!busy_r || (take && done)) && !q_empty;

  assign empty        = !busy_r;
  assign out_byte     = job_r.bytes[idx_r];
  assign out_has_data = job_r.has_data;
  assign out_last     = job_r.last && done;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (take && done) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_rdata;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= job_r.cnt)
    else $error("beat index past end of job");

  a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !job_r.has_data |-> job_r.cnt == 2'd0 && job_r.last)
    else $error("end marker not a single final beat");

endmodule

/* hw/rtl/base64_stream_codec.sv */
// base64 stream codec, standard alphabet. one byte enters per beat on the
// push/full side; results leave one per beat on the empty/pop side. cfg_data
// selects encode (0) or decode (1); a cfg write also drops any part-finished
// message, so write it only between messages. encode turns three bytes into
// four characters and, on the byte marked in_last, flushes a short group with
// zero fill and '=' padding. decode skips '=', treats any other character
// outside the alphabet as zero, emits a byte per eight bits gathered and
// drops leftover bits at the end. a last byte that yields nothing gives one
// end-marker beat with out_has_data low and out_last high.
// timing: the front end takes a byte every cycle while the job queue has
// room. an accepted byte's job is written into the queue, then loaded into
// the back end's job register, before its first result appears. the result
// port gives one beat per cycle while pop is held, so it sets the sustained
// rate when encoding (four beats per three bytes, up to four beats on a final
// byte); decoding gives at most one beat per byte.
module base64_stream_codec #(
  parameter int JOB_DEPTH = b64c_pkg::JOB_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_data,
  // input beats
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // result beats
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_has_data,
  output logic       out_last
);

  b64c_pkg::job_t job_in, job_out;
  logic           accept, job_valid, q_full, q_empty, q_pop;

  // full only reflects the job queue, so input stalls only once waiting results fill it
  assign full   = q_full;
  assign accept = push && !q_full;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .job_valid (job_valid),
    .job       (job_in)
  );

  // short queue of per-byte jobs decouples classification from beat output
  b64c_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .wdata (job_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  // back end walks each job one beat at a time
  b64c_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_rdata      (job_out),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_has_data (out_has_data),
    .out_last     (out_last)
  );

endmodule
